/* hw/rtl/ips_pkg.sv */
// ips_pkg: shared types and constants for the IRC parameter splitter.
// Used by ips_front, ips_queue, ips_back and irc_parameter_splitter.
package ips_pkg;

  localparam int MaxParamsDefault = 16;
  localparam int QueueDepth       = 4;
  localparam int QueuePtrW        = $clog2(QueueDepth);

  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChSpace = 8'h20;

  typedef enum logic [2:0] {
    ROLE_SEP         = 3'd0,
    ROLE_TOK_FIRST   = 3'd1,
    ROLE_TOK         = 3'd2,
    ROLE_TRAIL_FIRST = 3'd3,
    ROLE_TRAIL       = 3'd4,
    ROLE_DROP        = 3'd5,
    ROLE_NONE        = 3'd6
  } role_t;

  // One queue entry: up to two bytes to label, produced by one input transaction.
  typedef struct packed {
    logic       a_valid;
    logic [7:0] a_byte;
    logic       a_next_colon;
    logic       b_valid;
    logic [7:0] b_byte;
    logic       eom;
  } ips_entry_t;

  // Per-message tokenizer state.
  typedef struct packed {
    logic       prev_space;
    logic       at_start;
    logic       in_trailing;
    logic       limit;
    logic       trailing_seen;
    logic [8:0] tokens;
  } tok_state_t;

  localparam tok_state_t TokStateClear = '{
    prev_space:    1'b0,
    at_start:      1'b1,
    in_trailing:   1'b0,
    limit:         1'b0,
    trailing_seen: 1'b0,
    tokens:        9'd1
  };

endpackage

/* hw/rtl/ips_front.sv */
// ips_front: accepts input transactions, holds one byte back, builds queue entries.
// Depends on ips_pkg.
module ips_front
  import ips_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [7:0] data_byte,
  input  logic       has_byte,
  input  logic       end_of_message,
  input  logic       q_full,
  output logic       q_push,
  output ips_entry_t q_entry
);

  logic       held_valid;
  logic [7:0] held_byte;
  logic       accept;

  assign item_stall = q_full;
  assign accept     = item_valid && !item_stall;
  assign q_push     = accept && (end_of_message || (has_byte && held_valid));

  always_comb begin
    q_entry.a_valid      = held_valid;
    q_entry.a_byte       = held_byte;
    q_entry.a_next_colon = has_byte && (data_byte == ChColon);
    q_entry.b_valid      = end_of_message && has_byte;
    q_entry.b_byte       = data_byte;
    q_entry.eom          = end_of_message;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      if (end_of_message) begin
        held_valid <= 1'b0;
      end else if (has_byte) begin
        held_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_byte && !end_of_message) begin
      held_byte <= data_byte;
    end
  end

endmodule

/* hw/rtl/ips_queue.sv */
// ips_queue: short FIFO of label entries between front and back.
// Depends on ips_pkg.
module ips_queue
  import ips_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  ips_entry_t push_entry,
  input  logic       pop,
  output logic       full,
  output logic       empty,
  output ips_entry_t head
);

  ips_entry_t             slots [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr;
  logic [QueuePtrW-1:0]   rd_ptr;
  logic [QueuePtrW:0]     count;

  assign full  = (count == (QueuePtrW+1)'(QueueDepth));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/ips_back.sv */
// ips_back: labels queued bytes one per cycle unless stalled and drives the
// result register. Depends on ips_pkg.
module ips_back
  import ips_pkg::*;
#(
  parameter int MAX_PARAMS = MaxParamsDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  ips_entry_t q_head,
  output logic       q_pop,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] out_byte,
  output logic [2:0] role,
  output logic [7:0] token_index,
  output logic       message_done,
  output logic [8:0] param_count
);

  localparam logic [8:0] MaxTok = 9'(MAX_PARAMS);

  tok_state_t st;
  tok_state_t st_next;
  tok_state_t lab;
  logic       phase;
  logic       advance;
  logic       sel_b;
  logic       no_byte;
  logic       done;
  logic [7:0] cur_byte;
  logic       cur_next_colon;
  role_t      cur_role;

  assign advance = !q_empty && (!result_valid || !result_stall);
  assign sel_b   = phase || !q_head.a_valid;
  assign no_byte = sel_b && !q_head.b_valid;
  assign done    = q_head.eom && (sel_b || !q_head.b_valid);
  assign q_pop   = advance && (sel_b || !(q_head.eom && q_head.b_valid));

  assign cur_byte       = no_byte ? 8'd0 : (sel_b ? q_head.b_byte : q_head.a_byte);
  assign cur_next_colon = sel_b ? 1'b0 : q_head.a_next_colon;

  // Labeling rules for one byte.
  always_comb begin
    lab      = st;
    cur_role = ROLE_NONE;
    if (!no_byte) begin
      if (st.in_trailing) begin
        if (st.limit) begin
          cur_role = ROLE_DROP;
        end else if (!st.trailing_seen) begin
          cur_role          = ROLE_TRAIL_FIRST;
          lab.trailing_seen = 1'b1;
        end else begin
          cur_role = ROLE_TRAIL;
        end
      end else if (cur_byte == ChColon && st.prev_space && !st.at_start) begin
        lab.in_trailing = 1'b1;
        cur_role        = ROLE_SEP;
        if (!st.limit && st.tokens < MaxTok) begin
          lab.tokens = st.tokens + 9'd1;
        end
      end else if (cur_byte == ChSpace) begin
        cur_role = (st.limit && !cur_next_colon) ? ROLE_TOK : ROLE_SEP;
      end else if (st.limit) begin
        cur_role = ROLE_TOK;
      end else if (st.prev_space) begin
        if (st.tokens < MaxTok) begin
          lab.tokens = st.tokens + 9'd1;
        end
        cur_role = ROLE_TOK_FIRST;
        if (lab.tokens >= MaxTok) begin
          lab.limit = 1'b1;
        end
      end else if (st.at_start) begin
        cur_role = ROLE_TOK_FIRST;
      end else begin
        cur_role = ROLE_TOK;
      end
      lab.prev_space = (cur_byte == ChSpace);
      lab.at_start   = 1'b0;
    end
  end

  assign st_next = done ? TokStateClear : lab;

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= TokStateClear;
      phase        <= 1'b0;
      result_valid <= 1'b0;
    end else if (advance) begin
      st           <= st_next;
      phase        <= !q_pop;
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte     <= cur_byte;
      role         <= cur_role;
      token_index  <= 8'(lab.tokens - 9'd1);
      message_done <= done;
      param_count  <= done ? lab.tokens : 9'd0;
    end
  end

endmodule

/* hw/rtl/irc_parameter_splitter.sv */
// irc_parameter_splitter: top level of the IRC message parameter tokenizer.
// Depends on ips_pkg, ips_front, ips_queue, ips_back.
//
// Usage:
//  - Input channel (item_valid / item_stall): one message byte per transaction,
//    has_byte marks a real byte, end_of_message marks the final transaction.
//    An empty end marker (has_byte 0) closes a message.
//  - Result channel (result_valid / result_stall): one labeled byte per
//    transaction, with its role, token index, and on the last result of a
//    message message_done and param_count.
//  - A byte is labeled once the next byte arrives (space-colon lookahead), so
//    a byte is queued once the following input transaction is accepted, then
//    reaches the result register. End of message releases the held byte too.
//  - Throughput unless stalled: one input transaction per clock; the labeling
//    unit emits one result per clock; an end of message carrying a byte while
//    another is held yields two; the 4-entry front-to-back queue absorbs them.
//  - item_stall rises only when that queue is full, i.e. when result_stall has
//    held the output register long enough to back the queue up.
//  - Reset (rst, synchronous) empties the queue and the output register and
//    returns the tokenizer to message start with one token counted.
module irc_parameter_splitter
  import ips_pkg::*;
#(
  parameter int MAX_PARAMS = MaxParamsDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [7:0] data_byte,
  input  logic       has_byte,
  input  logic       end_of_message,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] out_byte,
  output logic [2:0] role,
  output logic [7:0] token_index,
  output logic       message_done,
  output logic [8:0] param_count
);

  // Front to queue
  logic       q_push;
  ips_entry_t q_push_entry;
  logic       q_full;

  // Queue to back
  logic       q_pop;
  logic       q_empty;
  ips_entry_t q_head;

  // Front: handshake, byte hold-back, entry build
  ips_front u_front (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .data_byte      (data_byte),
    .has_byte       (has_byte),
    .end_of_message (end_of_message),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_entry        (q_push_entry)
  );

  // Decoupling queue
  ips_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_push_entry),
    .pop        (q_pop),
    .full       (q_full),
    .empty      (q_empty),
    .head       (q_head)
  );

  // Back: tokenizer state and result register
  ips_back #(
    .MAX_PARAMS (MAX_PARAMS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_byte     (out_byte),
    .role         (role),
    .token_index  (token_index),
    .message_done (message_done),
    .param_count  (param_count)
  );

  // Final result of a message carries a count within the limit
  a_count_on_done: assert property (@(posedge clk) disable iff (rst)
    result_valid && message_done |-> param_count != 9'd0 && param_count <= 9'(MAX_PARAMS))
    else $error("param_count out of range on message end");

  // Count is zero on every other result
  a_count_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !message_done |-> param_count == 9'd0)
    else $error("param_count set before message end");

  // Token index stays below the limit
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> 9'(token_index) < 9'(MAX_PARAMS))
    else $error("token_index beyond limit");

  // Queue never pushed while full, never popped while empty
  a_queue_safe: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full) && !(q_pop && q_empty))
    else $error("queue overflow or underflow");

endmodule
